/* rtl/dtbw_pkg.sv */
// Shared types, constants and helper functions for the date to BCD converter.
package dtbw_pkg;

	localparam logic [11:0] YEAR_BASE = 12'd1980;
	localparam logic [11:0] YEAR_LAST = 12'd2079;
	localparam logic [7:0]  MONTH_FEB = 8'd2;
	localparam logic [7:0]  MONTH_APR = 8'd4;
	localparam logic [7:0]  MONTH_JUN = 8'd6;
	localparam logic [7:0]  MONTH_SEP = 8'd9;
	localparam logic [7:0]  MONTH_NOV = 8'd11;
	localparam logic [7:0]  MONTH_MAX = 8'd12;
	localparam logic [7:0]  DAY_MAX   = 8'd31;
	localparam logic [7:0]  FEB_LEAP  = 8'd29;
	localparam logic [7:0]  FEB_COMMON = 8'd28;
	localparam logic [31:0] BAD_WORD  = 32'hffff_ffff;

	// weekday offset of the first of each month, common and leap years
	localparam logic [2:0] MONTH_START_COMMON [12] =
		'{3'd0, 3'd3, 3'd3, 3'd6, 3'd1, 3'd4, 3'd6, 3'd2, 3'd5, 3'd0, 3'd3, 3'd5};
	localparam logic [2:0] MONTH_START_LEAP [12] =
		'{3'd0, 3'd3, 3'd4, 3'd0, 3'd2, 3'd5, 3'd0, 3'd3, 3'd6, 3'd1, 3'd4, 3'd6};
	// shift per four-year cycle (mod 7) and per year within the cycle
	localparam logic [2:0] CYCLE_SHIFT [7] =
		'{3'd2, 3'd0, 3'd5, 3'd3, 3'd1, 3'd6, 3'd4};
	localparam logic [2:0] PHASE_SHIFT [4] = '{3'd0, 3'd2, 3'd3, 3'd4};

	typedef struct packed {
		logic [11:0] full_year;
		logic [7:0]  month_number;
		logic [7:0]  day_number;
	} in_item_t;

	typedef struct packed {
		logic [31:0] packed_bcd_date;
		logic        date_invalid;
	} out_item_t;

	// x mod 7 for x below 56: three compare-and-subtract steps
	function automatic logic [2:0] mod7(input logic [5:0] x);
		logic [5:0] r;
		r = x;
		if (r >= 6'd28) begin
			r = r - 6'd28;
		end
		if (r >= 6'd14) begin
			r = r - 6'd14;
		end
		if (r >= 6'd7) begin
			r = r - 6'd7;
		end
		return r[2:0];
	endfunction

	// two BCD digits of v (0..99); tens by reciprocal multiply (exact below 179)
	function automatic logic [7:0] bcd2(input logic [6:0] v);
		logic [13:0] p;
		logic [3:0]  t;
		logic [6:0]  r;
		p = 14'(v) * 14'd103;
		t = p[13:10];
		r = v - ({3'b000, t} << 3) - ({3'b000, t} << 1);
		return {t, r[3:0]};
	endfunction

endpackage

/* rtl/date_to_bcd_with_weekday.sv */
// Top level: binary calendar date to packed BCD date with day of week.
//
// Input channel (item_valid / item_stall / item) carries a binary date:
// 12-bit full year, month and day. Output channel (result_valid /
// result_stall / result) carries the packed word and the invalid flag.
// A transfer takes place on a rising edge with valid high and stall low.
// Packed word: leap phase [31:28], weekday [27:24] (0 = Sunday), BCD year
// offset from 1980 [23:16], BCD month [15:8], BCD day [7:0]. Dates outside
// 1980..2079 or with a bad month or day give all ones and date_invalid = 1.
// Path: the date lands in the input register on its transfer edge; the
// result register loads from it whenever it is empty or the receiver does
// not stall. Throughput: one date per cycle unless the receiver stalls;
// the conversion is a single pass of small table lookups and narrow adds
// between the two registers.
// When the receiver stalls, the result register holds; the input register
// still takes one more date, after which item_stall rises until the result
// is taken. Reset empties both stages; no result is offered after reset.
module date_to_bcd_with_weekday (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  dtbw_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_stall,
	output dtbw_pkg::out_item_t result
);
	import dtbw_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	out_item_t result_s2;
	out_item_t conv_result;
	logic      advance;   // stage 1 may move into the result register
	logic      accept;

	assign advance    = !valid_s2 || !result_stall;
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	dtbw_conv u_conv (
		.item   (item_s1),
		.result (conv_result)
	);

	// stage 2: result register, held while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_s2 <= conv_result;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	// an invalid result always carries the all-ones word
	a_bad_word: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.date_invalid |-> result.packed_bcd_date == BAD_WORD)
		else $error("invalid result without all-ones word");

	// a valid date has weekday 0..6 and leap phase 0..3
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.date_invalid |->
			result.packed_bcd_date[27:24] <= 4'd6 && result.packed_bcd_date[31:30] == 2'b00)
		else $error("weekday or phase out of range");

	// input backpressure only while both stages are full and the output stalls
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && result_valid && result_stall)
		else $error("input stalled without a full pipeline");

	// a transfer in always fills stage 1 on the next cycle
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted item lost");

	// stage 1 contents reach the output when the result register is free
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> result_valid)
		else $error("stage 1 item not moved to result register");

endmodule

/* rtl/dtbw_conv.sv */
// Combinational date check, weekday and BCD packing for one item.
module dtbw_conv (
	input  dtbw_pkg::in_item_t  item,
	output dtbw_pkg::out_item_t result
);
	import dtbw_pkg::*;

	logic        year_ok, range_ok, len_ok;
	logic [11:0] year_diff;
	logic [6:0]  off;
	logic [1:0]  phase;
	logic [3:0]  month_idx;
	logic [4:0]  day_m1;
	logic [2:0]  cycle_idx;
	logic [2:0]  month_wd;
	logic [5:0]  wd_sum;
	logic [2:0]  wd;

	assign year_ok   = (item.full_year >= YEAR_BASE) && (item.full_year <= YEAR_LAST);
	assign range_ok  = year_ok
		&& (item.month_number != 8'd0) && (item.month_number <= MONTH_MAX)
		&& (item.day_number != 8'd0) && (item.day_number <= DAY_MAX);
	assign year_diff = item.full_year - YEAR_BASE;
	assign off       = year_ok ? year_diff[6:0] : 7'd0;
	assign phase     = off[1:0];

	always_comb begin
		len_ok = 1'b1;
		if (item.month_number == MONTH_FEB) begin
			len_ok = item.day_number <= ((phase != 2'd0) ? FEB_COMMON : FEB_LEAP);
		end else if (item.day_number == DAY_MAX && (item.month_number == MONTH_APR
				|| item.month_number == MONTH_JUN || item.month_number == MONTH_SEP
				|| item.month_number == MONTH_NOV)) begin
			len_ok = 1'b0;
		end
	end

	// indexes are only meaningful once the range checks pass
	assign month_idx = range_ok ? (item.month_number[3:0] - 4'd1) : 4'd0;
	assign day_m1    = item.day_number[4:0] - 5'd1;
	assign cycle_idx = mod7({1'b0, off[6:2]});
	assign month_wd  = (phase != 2'd0) ? MONTH_START_COMMON[month_idx]
	                                   : MONTH_START_LEAP[month_idx];
	assign wd_sum    = 6'(month_wd) + 6'(CYCLE_SHIFT[cycle_idx])
		+ 6'(PHASE_SHIFT[phase]) + 6'(day_m1);
	assign wd        = mod7(wd_sum);

	always_comb begin
		if (range_ok && len_ok) begin
			result.packed_bcd_date = {2'b00, phase, 1'b0, wd, bcd2(off),
				bcd2(item.month_number[6:0]), bcd2(item.day_number[6:0])};
			result.date_invalid    = 1'b0;
		end else begin
			result.packed_bcd_date = BAD_WORD;
			result.date_invalid    = 1'b1;
		end
	end

endmodule
